// ===== sv/nchm_pkg.sv =====
// nchm_pkg: shared constants, opcodes and command struct for the
// nearest-code Hamming matcher. No dependencies.
package nchm_pkg;

    localparam int ENTRIES   = 16;
    localparam int CODE_BITS = 20;
    localparam int IDX_W     = 4;    // entry_index / match_index width
    localparam int DIST_W    = 5;    // Hamming distance width
    localparam int CNT_W     = 5;    // entry_count width, holds ENTRIES itself

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);

    // controller to datapath commands
    typedef struct packed {
        logic             wr;       // store the input code at entry_index
        logic             start;    // latch query code, clear best-so-far
        logic             rd_en;    // read one table entry
        logic [IDX_W-1:0] rd_addr;
        logic             load;     // move best-so-far into the output register
    } t_dp_cmd;

    // number of set bits in a code word
    function automatic logic [DIST_W-1:0] bit_count(input logic [CODE_BITS-1:0] v);
        logic [DIST_W-1:0] n;
        n = '0;
        for (int b = 0; b < CODE_BITS; b++) begin
            n = n + DIST_W'(v[b]);
        end
        return n;
    endfunction

endpackage

// ===== sv/nchm_datapath.sv =====
// nchm_datapath: code table memory, Hamming compare and best-match tracking,
// output payload register. Depends on nchm_pkg.
module nchm_datapath (
    input  logic                             i_clk,
    input  nchm_pkg::t_dp_cmd                i_cmd,
    input  logic [nchm_pkg::IDX_W-1:0]       i_entry_index,
    input  logic [nchm_pkg::CODE_BITS-1:0]   i_code_value,
    output logic                             o_found,
    output logic [nchm_pkg::IDX_W-1:0]       o_match_index,
    output logic [nchm_pkg::DIST_W-1:0]      o_distance,
    output logic                             o_exact
);
    import nchm_pkg::*;

    logic [CODE_BITS-1:0] r_table [ENTRIES];
    logic [CODE_BITS-1:0] r_rd_data;
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_rd_vld;
    logic [CODE_BITS-1:0] r_code;

    logic                 r_found;
    logic                 r_exact;
    logic [IDX_W-1:0]     r_best_idx;
    logic [DIST_W-1:0]    r_best_dist;

    logic [DIST_W-1:0]    w_dist;
    logic                 w_hit;

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_table[i_entry_index] <= i_code_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_table[i_cmd.rd_addr];
        end
        r_rd_idx <= i_cmd.rd_addr;
        r_rd_vld <= i_cmd.rd_en;
    end

    // distance of the entry read last cycle
    assign w_dist = bit_count(r_rd_data ^ r_code);
    assign w_hit  = (r_rd_data == r_code);

    // best-so-far; an exact hit freezes the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_code      <= i_code_value;
            r_found     <= 1'b0;
            r_exact     <= 1'b0;
            r_best_idx  <= '0;
            r_best_dist <= '0;
        end else if (r_rd_vld && !r_exact) begin
            if (w_hit) begin
                r_found     <= 1'b1;
                r_exact     <= 1'b1;
                r_best_idx  <= r_rd_idx;
                r_best_dist <= '0;
            end else if (!r_found || (w_dist < r_best_dist)) begin
                r_found     <= 1'b1;
                r_best_idx  <= r_rd_idx;
                r_best_dist <= w_dist;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_found       <= r_found;
            o_match_index <= r_best_idx;
            o_distance    <= r_best_dist;
            o_exact       <= r_exact;
        end
    end

endmodule

// ===== sv/nchm_ctrl.sv =====
// nchm_ctrl: handshake, entry_count register and scan sequencer.
// Drives nchm_datapath through t_dp_cmd. Depends on nchm_pkg.
module nchm_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_cfg_wr_en,
    input  logic [nchm_pkg::CNT_W-1:0]   i_cfg_wr_data,
    output nchm_pkg::t_dp_cmd            o_cmd
);
    import nchm_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH, S_OUT} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_entry_count;
    logic [CNT_W-1:0] r_limit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;

    logic             w_accept;
    logic             w_out_free;
    logic [CNT_W-1:0] w_limit;
    logic [CNT_W-1:0] w_cnt_inc;

    // input held off during reset and while a query is in progress
    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_limit     = (r_entry_count > ENTRIES_CNT) ? ENTRIES_CNT : r_entry_count;
    assign w_cnt_inc   = r_cnt + CNT_W'(1);

    // datapath commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.wr      = w_accept && (i_operation == OP_WRITE);
        o_cmd.start   = w_accept && (i_operation == OP_QUERY);
        o_cmd.rd_en   = (r_state == S_SCAN);
        o_cmd.rd_addr = r_cnt[IDX_W-1:0];
        o_cmd.load    = (r_state == S_OUT) && w_out_free;
    end

    // state, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_limit       <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_entry_count <= i_cfg_wr_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.start) begin
                        r_cnt   <= '0;
                        r_limit <= w_limit;
                        r_state <= (w_limit == '0) ? S_FLUSH : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= w_cnt_inc;
                    if (w_cnt_inc == r_limit) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // scan never reads past the search limit
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt < r_limit))
        else $error("scan address beyond limit");

    // a result is never loaded over one still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !(r_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    // a write transaction keeps the block idle
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr |=> (r_state == S_IDLE))
        else $error("write left idle state");

    // output valid only rises out of the output state
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("output valid raised outside output state");

endmodule

// ===== sv/nearest_code_hamming_match.sv =====
// nearest_code_hamming_match: top level of the nearest-code Hamming matcher.
// Instantiates nchm_ctrl and nchm_datapath; depends on nchm_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction of
//   operation, entry_index and code_value. Operation write stores the code in
//   the table slot and gives no result. Operation query scans slots 0 to
//   entry_count-1 (entry_count saturated at 16) and gives one result on the
//   output channel (o_out_valid / i_out_stall): found, match_index,
//   distance, exact.
//   Flow: an accepted query scans the table, lets the last compare settle,
//   then waits until the output register is free to load the result; the
//   block takes no new transaction until it is back in idle. The scan reads
//   one table entry per cycle through the single memory read port.
//   Configuration: i_cfg_wr_en / i_cfg_wr_data write entry_count; write it
//   only while the block is idle.
//   Reset clears control state and entry_count to 0 and stalls the input while
//   held; table contents are undefined until written. A stalled result holds
//   in the output register; a new query may scan meanwhile and then waits
//   until that result is taken.
module nearest_code_hamming_match (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_operation,
    input  logic [nchm_pkg::IDX_W-1:0]           i_entry_index,
    input  logic [nchm_pkg::CODE_BITS-1:0]       i_code_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_found,
    output logic [nchm_pkg::IDX_W-1:0]           o_match_index,
    output logic [nchm_pkg::DIST_W-1:0]          o_distance,
    output logic                                 o_exact,
    input  logic                                 i_cfg_wr_en,
    input  logic [nchm_pkg::CNT_W-1:0]           i_cfg_wr_data
);
    import nchm_pkg::*;

    t_dp_cmd w_cmd;

    // sequencer
    nchm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cmd         (w_cmd)
    );

    // table and compare
    nchm_datapath u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_entry_index (i_entry_index),
        .i_code_value  (i_code_value),
        .o_found       (o_found),
        .o_match_index (o_match_index),
        .o_distance    (o_distance),
        .o_exact       (o_exact)
    );

endmodule
